@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies; included by the top level of the histogram core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/mshh_pkg.sv @@
// Shared types and constants of the multiply-shift hash histogram core.
// No dependencies; imported by every module of the core.
`default_nettype none

package mshh_pkg;

    localparam int MAX_BITS_DEF = 10;
    localparam int WORD_W       = 32;
    localparam int BKT_W        = 10;
    localparam int CMD_W        = 3;
    localparam int IDX_W        = 2;
    localparam int BITS_W       = 4;
    localparam int K_W          = 5;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 48;
    localparam int M_PAD_W      = M_TDATA_W - WORD_W - BKT_W;

    localparam logic [WORD_W-1:0] MULT_A_RST      = 32'd2654435761;
    localparam logic [WORD_W-1:0] OFFSET_B_RST    = 32'd0;
    localparam logic [BITS_W-1:0] BUCKET_BITS_RST = 4'd10;
    localparam logic [WORD_W-1:0] COUNT_MAX       = 32'hFFFF_FFFF;

    localparam logic [IDX_W-1:0] REG_MULT_A      = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_B    = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUCKET_BITS = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_HASH  = 3'd1,
        CMD_COUNT = 3'd2,
        CMD_SWEEP = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_BKT,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] mult_a;
        logic [WORD_W-1:0] offset_b;
        logic [BITS_W-1:0] bucket_bits;
    } cfg_t;

    typedef struct packed {
        logic              empty;
        logic [WORD_W-1:0] count;
        logic [BKT_W-1:0]  bucket;
    } res_t;

endpackage

`default_nettype wire

@@ design/multiply_shift_hash_histogram_core.sv @@
// Top level of the multiply-shift hash histogram: configuration registers, output stage.
// Depends on mshh_pkg, mshh_hash, mshh_ram, mshh_seq and assert_macros.svh.
//
// Channel  Direction  Handshake              Payload
// s_*      in         s_tvalid / s_tready    tuser: command; tdata: address, range_end, read_bucket
// m_*      out        m_tvalid / m_tready    tuser: empty_range; tdata: bucket_out, count_value
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Hash only and hash and count go through the two-stage hash unit, then a counter read and update;
// read skips the hash; a sweep repeats both per address, each a single RAM read-modify-write.
// Clear writes zero to every counter, one counter written per cycle.
// After reset all 2^MAX_BITS counters are cleared before s_tready rises; cfg is always ready.
// A result waits in the output register while the next word is accepted; a stalled m_tready
// holds the sequencer only once a second result is ready.
`default_nettype none

`include "assert_macros.svh"

module multiply_shift_hash_histogram_core #(
    parameter int MAX_BITS = mshh_pkg::MAX_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // address[31:0], range_end[63:32], read_bucket[73:64], zero fill [79:74]
    input  wire logic [mshh_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[2:0]
    input  wire logic [mshh_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // bucket_out[9:0], count_value[41:10], zero fill [47:42]
    output logic      [mshh_pkg::M_TDATA_W-1:0]   m_tdata,
    // empty_range[0]
    output logic                                  m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mshh_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [mshh_pkg::WORD_W-1:0]      cfg_data
);
    import mshh_pkg::*;

    cfg_t                cfg_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic [WORD_W-1:0]   hash_x;
    logic [MAX_BITS-1:0] bucket;
    logic                ram_we;
    logic [MAX_BITS-1:0] ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [MAX_BITS-1:0] ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                out_free;
    logic                res_load;
    res_t                res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mult_a      <= MULT_A_RST;
            cfg_reg.offset_b    <= OFFSET_B_RST;
            cfg_reg.bucket_bits <= BUCKET_BITS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MULT_A:      cfg_reg.mult_a      <= cfg_data;
                REG_OFFSET_B:    cfg_reg.offset_b    <= cfg_data;
                REG_BUCKET_BITS: cfg_reg.bucket_bits <= cfg_data[BITS_W-1:0];
                default:         ;
            endcase
        end
    end

    mshh_hash #(
        .MAX_BITS (MAX_BITS)
    ) u_hash (
        .clk    (clk),
        .cfg    (cfg_reg),
        .x      (hash_x),
        .bucket (bucket)
    );

    mshh_ram #(
        .AW (MAX_BITS),
        .DW (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mshh_seq #(
        .MAX_BITS (MAX_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .address     (s_tdata[31:0]),
        .range_end   (s_tdata[63:32]),
        .read_bucket (s_tdata[73:64]),
        .hash_x      (hash_x),
        .bucket      (bucket),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    // The output register is free when empty or when its word leaves this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_res_reg.count, out_res_reg.bucket};
    assign m_tuser  = out_res_reg.empty;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLY(a_empty_is_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[41:0] == 42'd0)
    `ASSERT_IMPLY(a_load_no_overwrite, clk, rst_n, res_load, !m_tvalid || m_tready)

endmodule

`default_nettype wire

@@ design/mshh_hash.sv @@
// Two-stage multiply-shift hash unit: product register, then offset add and top-bit select.
// Depends on mshh_pkg.
`default_nettype none

module mshh_hash #(
    parameter int MAX_BITS = mshh_pkg::MAX_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire mshh_pkg::cfg_t                cfg,
    input  wire logic [mshh_pkg::WORD_W-1:0]   x,
    output logic      [MAX_BITS-1:0]           bucket
);
    import mshh_pkg::*;

    logic [WORD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   y;
    logic [WORD_W-1:0]   shifted;
    logic [K_W-1:0]      k_raw;
    logic [K_W-1:0]      k_eff;
    logic [MAX_BITS-1:0] bucket_reg;
    logic [MAX_BITS-1:0] bucket_next;

    // Only the low word of the product matters, so the multiplier is 32 bits wide.
    assign prod = cfg.mult_a * x;

    assign k_raw = {1'b0, cfg.bucket_bits};
    assign k_eff = (k_raw > K_W'(MAX_BITS)) ? K_W'(MAX_BITS) : k_raw;

    always_comb
    begin
        y = prod_reg + cfg.offset_b;
        if (k_eff == '0)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = y >> (6'd32 - {1'b0, k_eff});
        end
        bucket_next = shifted[MAX_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod;
        bucket_reg <= bucket_next;
    end

    assign bucket = bucket_reg;

endmodule

`default_nettype wire

@@ design/mshh_ram.sv @@
// Simple dual-port counter memory: one write port, one read port with registered data.
// Depends on mshh_pkg for its parameter defaults and through the house import convention.
`default_nettype none

module mshh_ram #(
    parameter int AW = mshh_pkg::MAX_BITS_DEF,
    parameter int DW = mshh_pkg::WORD_W
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    import mshh_pkg::*;

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/mshh_seq.sv @@
// Command sequencer: clearing sweeps, hash pipeline timing and counter read-modify-write.
// Depends on mshh_pkg; drives mshh_hash input and mshh_ram ports.
`default_nettype none

module mshh_seq #(
    parameter int MAX_BITS = mshh_pkg::MAX_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mshh_pkg::CMD_W-1:0]    command,
    input  wire logic [mshh_pkg::WORD_W-1:0]   address,
    input  wire logic [mshh_pkg::WORD_W-1:0]   range_end,
    input  wire logic [mshh_pkg::BKT_W-1:0]    read_bucket,
    output logic      [mshh_pkg::WORD_W-1:0]   hash_x,
    input  wire logic [MAX_BITS-1:0]           bucket,
    output logic                               ram_we,
    output logic      [MAX_BITS-1:0]           ram_waddr,
    output logic      [mshh_pkg::WORD_W-1:0]   ram_wdata,
    output logic      [MAX_BITS-1:0]           ram_raddr,
    input  wire logic [mshh_pkg::WORD_W-1:0]   ram_rdata,
    input  wire logic                          out_free,
    output logic                               res_load,
    output mshh_pkg::res_t                     res
);
    import mshh_pkg::*;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;
    logic [WORD_W-1:0]   last_reg, last_next;
    logic [MAX_BITS-1:0] rb_reg, rb_next;
    logic [MAX_BITS-1:0] clr_reg, clr_next;
    res_t                res_reg, res_next;

    logic [MAX_BITS-1:0] rd_addr;
    logic [WORD_W-1:0]   rd_addr_w;
    logic [WORD_W-1:0]   rb_w;
    logic [WORD_W-1:0]   sat;

    assign rd_addr   = (cmd_reg == CMD_READ) ? rb_reg : bucket;
    assign rd_addr_w = WORD_W'(rd_addr);
    assign rb_w      = WORD_W'(read_bucket);
    assign sat       = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + WORD_W'(1);

    assign hash_x    = cur_reg;
    assign ram_raddr = rd_addr;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cur_reg  <= cur_next;
        last_reg <= last_next;
        rb_reg   <= rb_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        rb_next    = rb_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        s_tready   = 1'b0;
        res_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + MAX_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next  = command;
                    cur_next  = address;
                    last_next = range_end - WORD_W'(1);
                    rb_next   = rb_w[MAX_BITS-1:0];
                    res_next  = '0;
                    case (command)
                        CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_HASH, CMD_COUNT:
                        begin
                            state_next = ST_MUL;
                        end
                        CMD_SWEEP:
                        begin
                            if (range_end <= address)
                            begin
                                res_next.empty = 1'b1;
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_MUL;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + MAX_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_BKT;
            end
            ST_BKT:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The hash input is still held, so the bucket register still names this entry.
                res_next.bucket = rd_addr_w[BKT_W-1:0];
                if (cmd_reg == CMD_COUNT || cmd_reg == CMD_SWEEP)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = rd_addr;
                    ram_wdata      = sat;
                    res_next.count = sat;
                end
                else
                begin
                    res_next.count = ram_rdata;
                end
                if (cmd_reg == CMD_SWEEP && cur_reg != last_reg)
                begin
                    cur_next   = cur_reg + WORD_W'(1);
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_multiply_shift_hash_histogram_core.sv @@
// Self-checking testbench for multiply_shift_hash_histogram_core.
// Depends on mshh_pkg and the core; it keeps its own histogram and predicts every result word.
module tb_multiply_shift_hash_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mshh_pkg::*;

    localparam int MAX_BITS = MAX_BITS_DEF;
    localparam int DEPTH    = 1 << MAX_BITS;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] rend;
        logic [BKT_W-1:0]  rbkt;
    } hist_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    multiply_shift_hash_histogram_core #(.MAX_BITS(MAX_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the configuration and of the counter RAM.
    logic [WORD_W-1:0] cfg_mult   = MULT_A_RST;
    logic [WORD_W-1:0] cfg_offset = OFFSET_B_RST;
    logic [BITS_W-1:0] cfg_bits   = BUCKET_BITS_RST;
    logic [WORD_W-1:0] hist_counts [DEPTH];

    hist_req_t         command_queue[$];
    res_t              bucket_reports_due[$];
    logic [WORD_W-1:0] counted_addrs[$];
    hist_req_t         cur_req;
    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    int unsigned       stall_tick = 0;
    int unsigned       stall_mode = 0;
    int unsigned       hold_left = 0;
    int unsigned       mismatch_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [BKT_W-1:0] bucket_of(logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        int unsigned       k;
        y = cfg_mult * x + cfg_offset;
        k = (cfg_bits > MAX_BITS) ? MAX_BITS : cfg_bits;
        if (k == 0)
            return '0;
        return BKT_W'(y >> (WORD_W - k));
    endfunction

    function automatic void bump(logic [BKT_W-1:0] bk);
        if (hist_counts[bk] != COUNT_MAX)
            hist_counts[bk] = hist_counts[bk] + 1;
    endfunction

    // Applies one command to the shadow histogram and returns the word it must produce.
    function automatic res_t histogram_step(hist_req_t req);
        res_t             r;
        logic [BKT_W-1:0] bk;
        logic [WORD_W:0]  x;
        r = '0;
        case (req.cmd)
            CMD_CLEAR: begin
                foreach (hist_counts[i])
                    hist_counts[i] = '0;
            end
            CMD_HASH, CMD_COUNT: begin
                bk = bucket_of(req.addr);
                if (req.cmd == CMD_COUNT)
                    bump(bk);
                r.bucket = bk;
                r.count  = hist_counts[bk];
            end
            CMD_SWEEP: begin
                if (req.rend <= req.addr) begin
                    r.empty = 1'b1;
                end
                else begin
                    for (x = {1'b0, req.addr}; x < {1'b0, req.rend}; x++)
                        bump(bucket_of(x[WORD_W-1:0]));
                    bk       = bucket_of(req.rend - 1);
                    r.bucket = bk;
                    r.count  = hist_counts[bk];
                end
            end
            CMD_READ: begin
                r.bucket = req.rbkt;
                r.count  = hist_counts[req.rbkt];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Driver: words leave the command queue in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        logic nxt_valid;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                bucket_reports_due.insert(bucket_reports_due.size(), histogram_step(cur_req));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
                end
                if (gap_left != 0) begin
                    gap_left--;
                end
                else if (command_queue.size() != 0) begin
                    cur_req = command_queue.pop_front();
                    burst_left--;
                    nxt_valid = 1'b1;
                    s_tdata <= S_TDATA_W'({cur_req.rbkt, cur_req.rend, cur_req.addr});
                    s_tuser <= cur_req.cmd;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // Monitor: checks each result word against the oldest prediction and paces m_tready.
    always @(posedge clk or negedge rst_n) begin
        res_t exp_res;
        logic rdy;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (bucket_reports_due.size() == 0) begin
                    flag_mismatch("result word with nothing awaited", m_tdata[WORD_W-1:0], '0);
                end
                else begin
                    exp_res = bucket_reports_due.pop_front();
                    if (m_tdata[BKT_W-1:0] != exp_res.bucket)
                        flag_mismatch("bucket_out", m_tdata[BKT_W-1:0], exp_res.bucket);
                    if (m_tdata[BKT_W +: WORD_W] != exp_res.count)
                        flag_mismatch("count_value", m_tdata[BKT_W +: WORD_W], exp_res.count);
                    if (m_tuser != exp_res.empty)
                        flag_mismatch("empty_range", m_tuser, exp_res.empty);
                end
            end
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = (stall_tick % 4 != 3);
                2: rdy = 1'($urandom_range(0, 1));
                default: begin
                    // Alternating runs of ready and stall.
                    if (hold_left != 0) begin
                        hold_left--;
                        rdy = m_tready;
                    end
                    else begin
                        rdy       = !m_tready;
                        hold_left = $urandom_range(0, 24);
                    end
                end
            endcase
            m_tready <= rdy;
        end
    end

    function automatic hist_req_t make_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] addr,
                                           logic [WORD_W-1:0] rend, logic [BKT_W-1:0] rbkt);
        hist_req_t r;
        r.cmd  = cmd;
        r.addr = addr;
        r.rend = rend;
        r.rbkt = rbkt;
        return r;
    endfunction

    function automatic void queue_cmd(hist_req_t r);
        command_queue.insert(command_queue.size(), r);
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MULT_A:      cfg_mult   = data;
            REG_OFFSET_B:    cfg_offset = data;
            REG_BUCKET_BITS: cfg_bits   = data[BITS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                               logic [WORD_W-1:0] k_word, bit poke_spare);
        @(posedge clk);
        write_reg(REG_MULT_A, a);
        write_reg(REG_OFFSET_B, b);
        write_reg(REG_BUCKET_BITS, k_word);
        if (poke_spare)
            write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (command_queue.size() != 0 || s_tvalid || bucket_reports_due.size() != 0);
    endtask

    task automatic queue_random_item();
        int unsigned       roll;
        int unsigned       n;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] stop;
        logic [BKT_W-1:0]  rb;
        roll = $urandom_range(0, 99);
        addr = $urandom;
        rb   = BKT_W'($urandom);
        if (roll < 3) begin
            queue_cmd(make_req(CMD_CLEAR, addr, $urandom, rb));
        end
        else if (roll < 6) begin
            queue_cmd(make_req(CMD_W'($urandom_range(5, 7)), addr, $urandom, rb));
        end
        else if (roll < 61) begin
            // Reuse recent addresses so that counters climb past one.
            case ($urandom_range(0, 9))
                0, 1, 2, 3: if (counted_addrs.size() != 0)
                    addr = counted_addrs[$urandom_range(0, counted_addrs.size() - 1)];
                4: addr = ($urandom_range(0, 1) != 0) ? '0 : COUNT_MAX;
                default: ;
            endcase
            counted_addrs.insert(counted_addrs.size(), addr);
            if (counted_addrs.size() > 16)
                void'(counted_addrs.pop_front());
            queue_cmd(make_req((roll < 46) ? CMD_COUNT : CMD_HASH, addr, $urandom, rb));
        end
        else if (roll < 81) begin
            n = ($urandom_range(0, 59) == 0) ? $urandom_range(1024, 2048) : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0: addr = '0;
                1: addr = COUNT_MAX - n;
                default: ;
            endcase
            if (addr > COUNT_MAX - n)
                addr = COUNT_MAX - n;
            stop = addr + n;
            if ($urandom_range(0, 6) == 0)
                stop = ($urandom_range(0, 1) != 0) ? addr : addr - $urandom_range(0, addr);
            queue_cmd(make_req(CMD_SWEEP, addr, stop, rb));
        end
        else begin
            if ($urandom_range(0, 1) != 0 && counted_addrs.size() != 0)
                rb = bucket_of(counted_addrs[$urandom_range(0, counted_addrs.size() - 1)]);
            queue_cmd(make_req(CMD_READ, $urandom, $urandom, rb));
        end
    endtask

    initial begin
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] kw;
        foreach (hist_counts[i])
            hist_counts[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: extremes of the address, sweeps at both ends, empty sweeps.
        queue_cmd(make_req(CMD_READ, '0, '0, '0));
        queue_cmd(make_req(CMD_HASH, '0, COUNT_MAX, '1));
        queue_cmd(make_req(CMD_COUNT, '0, '0, '0));
        queue_cmd(make_req(CMD_COUNT, COUNT_MAX, '0, '0));
        queue_cmd(make_req(CMD_COUNT, 32'h5555_5555, 32'hAAAA_AAAA, 10'h2AA));
        queue_cmd(make_req(CMD_HASH, COUNT_MAX, '0, '0));
        queue_cmd(make_req(CMD_SWEEP, '0, 32'd16, '0));
        queue_cmd(make_req(CMD_SWEEP, 32'hFFFF_FFF0, COUNT_MAX, '0));
        queue_cmd(make_req(CMD_SWEEP, 32'd100, 32'd100, '0));
        queue_cmd(make_req(CMD_SWEEP, COUNT_MAX, '0, '0));
        queue_cmd(make_req(CMD_SWEEP, 32'd5, 32'd6, '0));
        queue_cmd(make_req(CMD_READ, '0, '0, '1));
        queue_cmd(make_req(CMD_READ, '0, '0, bucket_of('0)));
        queue_cmd(make_req(3'd5, $urandom, $urandom, BKT_W'($urandom)));
        queue_cmd(make_req(3'd6, $urandom, $urandom, BKT_W'($urandom)));
        queue_cmd(make_req(3'd7, COUNT_MAX, COUNT_MAX, '1));
        queue_cmd(make_req(CMD_CLEAR, '0, '0, '0));
        queue_cmd(make_req(CMD_READ, '0, '0, bucket_of('0)));
        wait_drained();

        // A single bucket in use, with the multiplier at zero and the offset at its top.
        load_config('0, COUNT_MAX, '0, 1'b1);
        queue_cmd(make_req(CMD_COUNT, $urandom, '0, '0));
        queue_cmd(make_req(CMD_SWEEP, 32'd10, 32'd20, '0));
        queue_cmd(make_req(CMD_HASH, COUNT_MAX, '0, '0));
        wait_drained();

        // A bucket width beyond the counter depth falls back to the full depth.
        load_config(32'd1, '0, 32'd15, 1'b0);
        queue_cmd(make_req(CMD_COUNT, COUNT_MAX, '0, '0));
        queue_cmd(make_req(CMD_SWEEP, 32'hFFC0_0000, 32'hFFC0_0100, '0));
        queue_cmd(make_req(CMD_READ, '0, '0, '1));
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 5))
                0: a = '0;
                1: a = 32'd1;
                2: a = COUNT_MAX;
                3: a = MULT_A_RST;
                4: a = $urandom | 32'd1;
                default: a = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0: b = '0;
                1: b = COUNT_MAX;
                default: b = $urandom;
            endcase
            kw = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                kw = ($urandom & ~32'hF) | kw;
            if (p == 0) begin
                a  = COUNT_MAX;
                b  = 32'h8000_0000;
                kw = 32'd1;
            end
            else if (p == 1) begin
                a  = MULT_A_RST;
                b  = OFFSET_B_RST;
                kw = 32'(BUCKET_BITS_RST);
            end
            load_config(a, b, kw, $urandom_range(0, 3) == 0);
            repeat (55) queue_random_item();
            wait_drained();
        end

        repeat (64) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_multiply_shift_hash_histogram_core passed");
        else
            $display("tb_multiply_shift_hash_histogram_core failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_multiply_shift_hash_histogram_core failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/mshh_pkg.sv
design/mshh_hash.sv
design/mshh_ram.sv
design/mshh_seq.sv
design/multiply_shift_hash_histogram_core.sv
tb/sv/tb_multiply_shift_hash_histogram_core.sv
